// ===== hdl/rgbhsv_pkg.sv =====
package rgbhsv_pkg;
  localparam int HUE_FRAC_BITS_DEF = 6;
  localparam int SAT_BITS_DEF      = 16;
  localparam int CH_W              = 8;
  localparam int HUE_INT_W         = 9;
  localparam int DEG_PER_SECTOR    = 60;
  localparam int DEG_FULL          = 360;

  // per-stage control that travels down the divider row
  typedef struct packed {
    logic vld;
    logic undef;
  } ctl_t;
endpackage

// ===== hdl/rgb_to_hsv_pixel.sv =====
// rgb to hsv converter for 8-bit pixels
// input: pulse start with in_red/in_green/in_blue; busy is always low, so a
//   new word can be given every clock cycle
// output: out_valid marks one cycle with out_hue, out_saturation, out_value
//   and out_hue_undefined; the receiver cannot stall and takes each word
//   in the cycle it appears
// pipeline: the front register, then the row of divider cells, one quotient
//   bit per cell
// throughput: one pixel per clock
// hue is in 1/2^HUE_FRAC_BITS degree, 0 up to below 360 degrees;
// saturation is delta/max as a SAT_BITS fraction clipped to all ones;
// black and grey pixels give hue 0 with out_hue_undefined set
// reset: rst_n low clears all valid flags in the row; words in flight are
//   dropped and no output is shown until new words arrive
module rgb_to_hsv_pixel #(
  parameter int HUE_FRAC_BITS = rgbhsv_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_BITS      = rgbhsv_pkg::SAT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rgbhsv_pkg::CH_W-1:0]         in_red,
  input  logic [rgbhsv_pkg::CH_W-1:0]         in_green,
  input  logic [rgbhsv_pkg::CH_W-1:0]         in_blue,
  output logic                                out_valid,
  output logic [rgbhsv_pkg::HUE_INT_W+HUE_FRAC_BITS-1:0] out_hue,
  output logic [SAT_BITS-1:0]                 out_saturation,
  output logic [rgbhsv_pkg::CH_W-1:0]         out_value,
  output logic                                out_hue_undefined
);
  import rgbhsv_pkg::*;

  localparam int HQ_W   = HUE_INT_W + HUE_FRAC_BITS;
  localparam int SQ_W   = SAT_BITS + 1;
  localparam int NCELL  = (HQ_W > SQ_W) ? HQ_W : SQ_W;
  localparam int N60_W  = HUE_INT_W + CH_W + 2;
  localparam int HN_W   = NCELL + N60_W;
  localparam int SN_W   = NCELL + CH_W;
  // full dividends with room for the bits that preload the remainder
  localparam int HP_W   = N60_W + HUE_FRAC_BITS + NCELL;
  localparam int SP_W   = CH_W + SAT_BITS + NCELL;

  ctl_t                ctl   [NCELL+1];
  logic [HN_W-1:0]     hnum  [NCELL+1];
  logic [CH_W:0]       hrem  [NCELL+1];
  logic [HQ_W-1:0]     hq    [NCELL+1];
  logic [SN_W-1:0]     snum  [NCELL+1];
  logic [CH_W:0]       srem  [NCELL+1];
  logic [SQ_W-1:0]     sq    [NCELL+1];
  logic [CH_W-1:0]     dlt   [NCELL+1];
  logic [CH_W-1:0]     mx    [NCELL+1];
  logic [HN_W-1:0]     hnum_front;
  logic [HP_W-1:0]     hpad;
  logic [SP_W-1:0]     spad;

  assign busy = 1'b0;

  rgbhsv_front #(.HN_W(HN_W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .ctl_r    (ctl[0]),
    .hnum_r   (hnum_front),
    .delta_r  (dlt[0]),
    .max_r    (mx[0])
  );

  // hue dividend n60 << HUE_FRAC_BITS; bits above the last NCELL go into
  // the starting remainder, which stays below delta since hue < 360 degrees
  assign hpad    = HP_W'(hnum_front[HN_W-1 -: N60_W]) << HUE_FRAC_BITS;
  assign hnum[0] = HN_W'(hpad[NCELL-1:0]) << (HN_W - NCELL);
  assign hrem[0] = (CH_W+1)'(hpad >> NCELL);
  assign hq[0]   = '0;
  // saturation dividend delta << SAT_BITS, split the same way
  assign spad    = SP_W'(dlt[0]) << SAT_BITS;
  assign snum[0] = SN_W'(spad[NCELL-1:0]) << (SN_W - NCELL);
  assign srem[0] = (CH_W+1)'(spad >> NCELL);
  assign sq[0]   = '0;

  // row of divider cells
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rgbhsv_div_cell #(.HN_W(HN_W), .SN_W(SN_W), .HQ_W(HQ_W), .SQ_W(SQ_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_in   (ctl[i]),
      .hnum_in  (hnum[i]),
      .hrem_in  (hrem[i]),
      .hq_in    (hq[i]),
      .snum_in  (snum[i]),
      .srem_in  (srem[i]),
      .sq_in    (sq[i]),
      .delta_in (dlt[i]),
      .max_in   (mx[i]),
      .ctl_r    (ctl[i+1]),
      .hnum_r   (hnum[i+1]),
      .hrem_r   (hrem[i+1]),
      .hq_r     (hq[i+1]),
      .snum_r   (snum[i+1]),
      .srem_r   (srem[i+1]),
      .sq_r     (sq[i+1]),
      .delta_r  (dlt[i+1]),
      .max_r    (mx[i+1])
    );
  end

  // outputs, saturation clipped, black and grey give zero hue and saturation
  always_comb begin
    out_valid         = ctl[NCELL].vld;
    out_hue_undefined = ctl[NCELL].undef;
    out_value         = mx[NCELL];
    out_hue           = ctl[NCELL].undef ? '0 : hq[NCELL];
    if (ctl[NCELL].undef) begin
      out_saturation = '0;
    end else begin
      out_saturation = sq[NCELL][SQ_W-1] ? '1 : sq[NCELL][SAT_BITS-1:0];
    end
  end
endmodule

// ===== hdl/rgbhsv_div_cell.sv =====
// one restoring step for both quotients: shift in the next dividend bit, try subtract
module rgbhsv_div_cell #(
  parameter int HN_W  = 24,
  parameter int SN_W  = 24,
  parameter int HQ_W  = 15,
  parameter int SQ_W  = 17
) (
  input  logic                 clk,
  input  rgbhsv_pkg::ctl_t     ctl_in,
  input  logic [HN_W-1:0]      hnum_in,
  input  logic [rgbhsv_pkg::CH_W:0] hrem_in,
  input  logic [HQ_W-1:0]      hq_in,
  input  logic [SN_W-1:0]      snum_in,
  input  logic [rgbhsv_pkg::CH_W:0] srem_in,
  input  logic [SQ_W-1:0]      sq_in,
  input  logic [rgbhsv_pkg::CH_W-1:0] delta_in,
  input  logic [rgbhsv_pkg::CH_W-1:0] max_in,
  input  logic                 rst_n,
  output rgbhsv_pkg::ctl_t     ctl_r,
  output logic [HN_W-1:0]      hnum_r,
  output logic [rgbhsv_pkg::CH_W:0] hrem_r,
  output logic [HQ_W-1:0]      hq_r,
  output logic [SN_W-1:0]      snum_r,
  output logic [rgbhsv_pkg::CH_W:0] srem_r,
  output logic [SQ_W-1:0]      sq_r,
  output logic [rgbhsv_pkg::CH_W-1:0] delta_r,
  output logic [rgbhsv_pkg::CH_W-1:0] max_r
);
  import rgbhsv_pkg::*;

  logic [CH_W+1:0] htry, stry;
  logic [CH_W:0]   hrem_nxt, srem_nxt;
  logic            hbit, sbit;

  // trial subtraction for hue and saturation
  always_comb begin
    htry = {hrem_in, hnum_in[HN_W-1]} - {2'b00, delta_in};
    stry = {srem_in, snum_in[SN_W-1]} - {2'b00, max_in};
    hbit = ~htry[CH_W+1];
    sbit = ~stry[CH_W+1];
    hrem_nxt = hbit ? htry[CH_W:0] : {hrem_in[CH_W-1:0], hnum_in[HN_W-1]};
    srem_nxt = sbit ? stry[CH_W:0] : {srem_in[CH_W-1:0], snum_in[SN_W-1]};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    hnum_r  <= {hnum_in[HN_W-2:0], 1'b0};
    snum_r  <= {snum_in[SN_W-2:0], 1'b0};
    hrem_r  <= hrem_nxt;
    srem_r  <= srem_nxt;
    hq_r    <= {hq_in[HQ_W-2:0], hbit};
    sq_r    <= {sq_in[SQ_W-2:0], sbit};
    delta_r <= delta_in;
    max_r   <= max_in;
  end
endmodule

// ===== hdl/rgbhsv_front.sv =====
// max/min, sector select and hue numerator, registered
module rgbhsv_front #(
  parameter int HN_W = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [rgbhsv_pkg::CH_W-1:0] in_red,
  input  logic [rgbhsv_pkg::CH_W-1:0] in_green,
  input  logic [rgbhsv_pkg::CH_W-1:0] in_blue,
  output rgbhsv_pkg::ctl_t     ctl_r,
  output logic [HN_W-1:0]      hnum_r,
  output logic [rgbhsv_pkg::CH_W-1:0] delta_r,
  output logic [rgbhsv_pkg::CH_W-1:0] max_r
);
  import rgbhsv_pkg::*;

  logic [CH_W-1:0] hi, lo, dlt;
  logic signed [CH_W+1:0] diff;
  logic [2:0]      sect;
  logic [HUE_INT_W+CH_W:0] nsum;
  logic [HUE_INT_W+CH_W+1:0] n60;

  // largest and smallest channel
  always_comb begin
    hi = (in_red > in_green) ? in_red : in_green;
    if (in_blue > hi) hi = in_blue;
    lo = (in_red < in_green) ? in_red : in_green;
    if (in_blue < lo) lo = in_blue;
    dlt = hi - lo;
  end

  // sector offset and difference, red wins ties then green
  always_comb begin
    if (in_red == hi) begin
      sect = 3'd0;
      diff = $signed({2'b00, in_green}) - $signed({2'b00, in_blue});
    end else if (in_green == hi) begin
      sect = 3'd2;
      diff = $signed({2'b00, in_blue}) - $signed({2'b00, in_red});
    end else begin
      sect = 3'd4;
      diff = $signed({2'b00, in_red}) - $signed({2'b00, in_green});
    end
    // wrap a negative red-sector hue by adding six sectors
    if (sect == 3'd0 && diff[CH_W+1]) begin
      nsum = (HUE_INT_W+CH_W+1)'(6 * dlt) + (HUE_INT_W+CH_W+1)'(diff);
    end else begin
      nsum = (HUE_INT_W+CH_W+1)'(sect) * (HUE_INT_W+CH_W+1)'(dlt)
           + (HUE_INT_W+CH_W+1)'(diff);
    end
    n60 = (HUE_INT_W+CH_W+2)'(nsum) * (HUE_INT_W+CH_W+2)'(DEG_PER_SECTOR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.vld   <= start;
      ctl_r.undef <= (dlt == '0);
    end
  end

  always_ff @(posedge clk) begin
    hnum_r  <= HN_W'(n60) << (HN_W - (HUE_INT_W + CH_W + 2));
    delta_r <= dlt;
    max_r   <= hi;
  end
endmodule
